### sv/u8d_pkg.sv
package u8d_pkg;

   // lead and continuation byte masks, the codes they must match, and the ASCII bound
   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] LEAD5_MASK = 8'hFC;
   localparam logic [7:0] LEAD5_CODE = 8'hF8;
   localparam logic [7:0] LEAD6_MASK = 8'hFE;
   localparam logic [7:0] LEAD6_CODE = 8'hFC;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] CONT_BITS  = 8'h3F;

   localparam int CP_W  = 31;
   localparam int LEN_W = 3;

   typedef enum logic [1:0] {
      KIND_OK       = 2'd0,
      KIND_LONG     = 2'd1,
      KIND_BAD_LEAD = 2'd2,
      KIND_TRUNC    = 2'd3
   } err_kind_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_bytes;
      err_kind_type     error_kind;
      logic             last_of_item;
   } entry_type;

   // up to two results per request, written to the queue together
   typedef struct packed {
      logic [1:0] count;
      entry_type  e0;
      entry_type  e1;
   } push_type;

   typedef struct packed {
      logic             single;   // one-byte result: ASCII or a bad lead
      logic             bad;
      logic [LEN_W-1:0] len;
      logic [4:0]       payload;
   } lead_type;

   function automatic lead_type classify_lead(logic [7:0] b);
      lead_type l;
      l = '0;
      if (b <= ASCII_MAX) begin
         l.single = 1'b1;
         l.len    = LEN_W'(1);
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         l.len     = LEN_W'(2);
         l.payload = b[4:0];
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         l.len     = LEN_W'(3);
         l.payload = {1'b0, b[3:0]};
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         l.len     = LEN_W'(4);
         l.payload = {2'b0, b[2:0]};
      end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
         l.len     = LEN_W'(5);
         l.payload = {3'b0, b[1:0]};
      end else if ((b & LEAD6_MASK) == LEAD6_CODE) begin
         l.len     = LEN_W'(6);
         l.payload = {4'b0, b[0]};
      end else begin
         l.single = 1'b1;
         l.bad    = 1'b1;
         l.len    = LEN_W'(1);
      end
      return l;
   endfunction

endpackage

### sv/u8d_front.sv
module u8d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_in,
   input  logic                q_low_space,
   output u8d_pkg::push_type   push
);

   logic [u8d_pkg::LEN_W-1:0] pend_ff, pend_in;
   logic [u8d_pkg::LEN_W-1:0] len_ff, len_in;
   logic [u8d_pkg::CP_W-1:0]  acc_ff, acc_in;
   logic                      long_ff, long_in;

   logic                      accept;
   logic                      is_cont;
   logic [u8d_pkg::CP_W-1:0]  acc_shift;
   u8d_pkg::lead_type         lead;
   u8d_pkg::entry_type        fresh;

   assign req_stall = q_low_space;
   assign accept    = req_valid && !req_stall;
   assign is_cont   = (req_byte_in & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_CODE;
   assign acc_shift = {acc_ff[u8d_pkg::CP_W-7:0], req_byte_in[5:0]};
   assign lead      = u8d_pkg::classify_lead(req_byte_in);

   // result of a one-byte form
   always_comb begin
      fresh.code_point   = u8d_pkg::CP_W'(req_byte_in);
      fresh.seq_bytes    = lead.len;
      fresh.error_kind   = lead.bad ? u8d_pkg::KIND_BAD_LEAD : u8d_pkg::KIND_OK;
      fresh.last_of_item = 1'b1;
   end

   always_comb begin
      pend_in    = pend_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      long_in    = long_ff;
      push.count = 2'd0;
      push.e0    = fresh;
      push.e1    = fresh;
      if (accept) begin
         if (pend_ff != '0 && is_cont) begin
            pend_in = pend_ff - u8d_pkg::LEN_W'(1);
            acc_in  = acc_shift;
            if (pend_ff == u8d_pkg::LEN_W'(1)) begin
               push.count           = 2'd1;
               push.e0.code_point   = acc_shift;
               push.e0.seq_bytes    = len_ff;
               push.e0.error_kind   = long_ff ? u8d_pkg::KIND_LONG : u8d_pkg::KIND_OK;
               push.e0.last_of_item = 1'b1;
               acc_in  = '0;
               len_in  = '0;
               long_in = 1'b0;
            end
         end else begin
            // truncated partial first, if a sequence was open
            if (pend_ff != '0) begin
               push.e0.code_point   = acc_ff;
               push.e0.seq_bytes    = len_ff - pend_ff;
               push.e0.error_kind   = u8d_pkg::KIND_TRUNC;
               push.e0.last_of_item = lead.single ? 1'b0 : 1'b1;
               push.count           = lead.single ? 2'd2 : 2'd1;
            end else begin
               push.count = lead.single ? 2'd1 : 2'd0;
            end
            if (lead.single) begin
               pend_in = '0;
               acc_in  = '0;
               len_in  = '0;
               long_in = 1'b0;
            end else begin
               pend_in = lead.len - u8d_pkg::LEN_W'(1);
               acc_in  = u8d_pkg::CP_W'(lead.payload);
               len_in  = lead.len;
               long_in = lead.len >= u8d_pkg::LEN_W'(5);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         len_ff  <= '0;
         acc_ff  <= '0;
         long_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         long_ff <= long_in;
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      pend_ff == '0 |-> (acc_ff == '0 && len_ff == '0 && !long_ff))
      else $error("decode state not clean with nothing pending");

   a_pend_below_len: assert property (@(posedge clock) disable iff (reset)
      pend_ff != '0 |-> (pend_ff < len_ff && len_ff <= u8d_pkg::LEN_W'(6)))
      else $error("pending count out of step with sequence length");

endmodule

### sv/u8d_queue.sv
module u8d_queue #(
   parameter int Depth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  u8d_pkg::push_type   push,
   output logic                low_space,
   input  logic                pop,
   output logic                empty,
   output u8d_pkg::entry_type  head
);

   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   u8d_pkg::entry_type   store_ff [Depth];
   logic [IdxW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [IdxW-1:0]      wr_next;

   function automatic logic [IdxW-1:0] wrap_inc(logic [IdxW-1:0] p);
      logic [IdxW-1:0] r;
      if (p == IdxW'(Depth - 1)) r = '0;
      else                       r = p + IdxW'(1);
      return r;
   endfunction

   assign wr_next   = wrap_inc(wr_ptr_ff);
   assign empty     = cnt_ff == '0;
   assign low_space = cnt_ff > CntW'(Depth - 2);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1)      wr_ptr_in = wr_next;
      else if (push.count == 2'd2) wr_ptr_in = wrap_inc(wr_next);
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) store_ff[wr_ptr_ff] <= push.e0;
      if (push.count == 2'd2) store_ff[wr_next]   <= push.e1;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> !low_space)
      else $error("queue written without room for two entries");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

endmodule

### sv/u8d_back.sv
module u8d_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  u8d_pkg::entry_type          q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [u8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic [u8d_pkg::LEN_W-1:0]   rsp_seq_bytes,
   output logic [1:0]                  rsp_error_kind,
   output logic                        rsp_error_seen,
   output logic                        rsp_last_of_item
);

   logic                       valid_ff;
   logic                       sticky_ff, sticky_in;
   u8d_pkg::entry_type         out_ff;

   // load whenever the output register is free or being taken
   assign q_pop     = !q_empty && (!valid_ff || !rsp_stall);
   assign sticky_in = sticky_ff || (q_head.error_kind != u8d_pkg::KIND_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         sticky_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            valid_ff  <= 1'b1;
            sticky_ff <= sticky_in;
         end else if (!rsp_stall) begin
            valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) out_ff <= q_head;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_code_point   = out_ff.code_point;
   assign rsp_seq_bytes    = out_ff.seq_bytes;
   assign rsp_error_kind   = out_ff.error_kind;
   assign rsp_error_seen   = sticky_ff;
   assign rsp_last_of_item = out_ff.last_of_item;

   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      sticky_ff |=> sticky_ff)
      else $error("sticky error flag cleared");

   a_error_flagged: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ff.error_kind != u8d_pkg::KIND_OK) |-> sticky_ff)
      else $error("error result shown without sticky flag");

endmodule

### sv/utf8_byte_stream_decoder.sv
// The first result of a request goes into the result queue, then the output register.
// Takes one byte per cycle while requests are not stalled; a byte that truncates a sequence
// and is itself a one-byte form yields two results, which leave the output register in turn.
// Requests stall while the result queue has fewer than two free entries.
// Reset (synchronous, active high) clears the decode state, queue pointers, the
// output valid and the sticky error flag; no clearing pass is needed.
module utf8_byte_stream_decoder #(
   parameter int QueueDepth = 4   // result queue entries, 2 or more
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_byte_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [u8d_pkg::CP_W-1:0]    rsp_code_point,
   output logic [u8d_pkg::LEN_W-1:0]   rsp_seq_bytes,
   output logic [1:0]                  rsp_error_kind,
   output logic                        rsp_error_seen,
   output logic                        rsp_last_of_item
);

   // front: takes a byte per request, tracks the open sequence and emits
   // zero, one or two finished entries (truncated partial, then fresh byte)
   u8d_pkg::push_type   push;
   logic                q_low_space;

   // back: pops one entry per cycle, while the output is not stalled, into the output register and
   // folds in the sticky error flag in result order
   logic                q_pop;
   logic                q_empty;
   u8d_pkg::entry_type  q_head;

   u8d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte_in (req_byte_in),
      .q_low_space (q_low_space),
      .push        (push)
   );

   // short queue decouples the two sides so each stalls on its own
   u8d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .low_space (q_low_space),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   u8d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_seq_bytes    (rsp_seq_bytes),
      .rsp_error_kind   (rsp_error_kind),
      .rsp_error_seen   (rsp_error_seen),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule
